@@ hw/rtl/ptts_pkg.sv @@
// ============================================================================
// ptts_pkg
// shared types and constants of the periodic task tick scheduler
// ============================================================================
package ptts_pkg;

    localparam int MS_W      = 20;
    localparam int HANDLE_W  = 16;
    localparam int TICKS_W   = 17;
    localparam int PEND_W    = 8;
    localparam int SLOT_W    = 4;

    // ms to 10 ms ticks: x / 10 == (x * ceil(2^23 / 10)) >> 23 for x < 2^22
    localparam int              TICK_SHIFT = 23;
    localparam int              PROD_W     = 2 * MS_W;
    localparam logic [MS_W-1:0] TICK_MUL   = 20'd838861;

    localparam logic [PEND_W-1:0] PEND_MAX = 8'hFF;

    // most results one dispatch request may give
    localparam int RESULT_CAP = 16;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef enum logic [1:0] {
        KIND_ADD      = 2'd0,
        KIND_TICK     = 2'd1,
        KIND_DISPATCH = 2'd2,
        KIND_CLEAR    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]          kind;
        logic [HANDLE_W-1:0] task_handle;
        logic [MS_W-1:0]     delay_ms;
        logic [MS_W-1:0]     period_ms;
    } t_item;

    typedef struct packed {
        logic                accepted;
        logic [SLOT_W-1:0]   slot;
        logic                run_valid;
        logic [HANDLE_W-1:0] run_handle;
        logic                last;
    } t_result;

    typedef struct packed {
        t_kind               kind;
        logic [HANDLE_W-1:0] handle;
        logic [TICKS_W-1:0]  delay_ticks;
        logic [TICKS_W-1:0]  period_ticks;
    } t_cmd;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TICKS_W-1:0]  delay;
        logic [TICKS_W-1:0]  period;
        logic [PEND_W-1:0]   pending;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_DSP_CHK,
        ST_DSP_EVAL,
        ST_SHIFT
    } t_state;

endpackage

@@ hw/rtl/ptts_ram.sv @@
// ============================================================================
// ptts_ram
// generic simple dual port ram, one write port, one registered read port
// ============================================================================
module ptts_ram #(
    parameter  int WIDTH = 58,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ptts_front.sv @@
// ============================================================================
// ptts_front
// request capture and conversion of ms fields into ticks
// ============================================================================
module ptts_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ptts_pkg::t_item  i_item,
    output logic             o_busy,
    input  logic             i_q_full,
    output logic             o_push,
    output ptts_pkg::t_cmd   o_cmd
);
    import ptts_pkg::*;

    logic                r_stg_valid;
    logic                n_stg_valid;
    t_item               r_stg;
    logic                accept;
    logic [PROD_W-1:0]   prod_delay;
    logic [PROD_W-1:0]   prod_period;

    assign o_busy = r_stg_valid & i_q_full;
    assign accept = i_start & ~o_busy;
    assign o_push = r_stg_valid & ~i_q_full;

    always_comb begin
        n_stg_valid = r_stg_valid;
        if (accept) begin
            n_stg_valid = 1'b1;
        end else if (o_push) begin
            n_stg_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else begin
            r_stg_valid <= n_stg_valid;
        end
        if (accept) begin
            r_stg <= i_item;
        end
    end

    // divide by ten through a reciprocal multiply
    assign prod_delay  = PROD_W'(r_stg.delay_ms) * PROD_W'(TICK_MUL);
    assign prod_period = PROD_W'(r_stg.period_ms) * PROD_W'(TICK_MUL);

    always_comb begin
        o_cmd.kind         = t_kind'(r_stg.kind);
        o_cmd.handle       = r_stg.task_handle;
        o_cmd.delay_ticks  = prod_delay[TICK_SHIFT +: TICKS_W];
        o_cmd.period_ticks = prod_period[TICK_SHIFT +: TICKS_W];
    end

endmodule

@@ hw/rtl/ptts_queue.sv @@
// ============================================================================
// ptts_queue
// short command queue between front and back
// ============================================================================
module ptts_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ptts_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ptts_pkg::t_cmd  o_head
);
    import ptts_pkg::*;

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_cnt;
    logic [QAW:0]     n_cnt;

    assign o_full  = r_cnt == (QAW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

@@ hw/rtl/ptts_back.sv @@
// ============================================================================
// ptts_back
// task table sequencer: add, tick walk, dispatch walk with compaction, clear
// ============================================================================
module ptts_back #(
    parameter int MAX_TASKS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  ptts_pkg::t_cmd    i_q_head,
    output logic              o_q_pop,
    output logic              o_strobe,
    output ptts_pkg::t_result o_result
);
    import ptts_pkg::*;

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int NW = $clog2(RESULT_CAP + 1);
    localparam logic [CW:0] ONE = (CW+1)'(1);
    localparam logic [CW:0] TWO = (CW+1)'(2);

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       n_idx;
    logic [CW-1:0]       r_sidx;
    logic [CW-1:0]       n_sidx;
    logic [NW-1:0]       r_nres;
    logic [NW-1:0]       n_nres;
    logic                r_hold_valid;
    logic                n_hold_valid;
    logic [HANDLE_W-1:0] r_hold_handle;
    logic [HANDLE_W-1:0] n_hold_handle;
    logic                r_out_valid;
    logic                n_out_valid;
    t_result             r_out;
    t_result             n_out;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    t_entry              ram_wdata;
    t_entry              ram_rdata;

    t_entry              tick_entry;
    t_entry              new_entry;
    t_result             ok_res;
    logic                table_full;
    logic                walk_end;
    logic                tick_last;
    logic                has_run;
    logic                one_shot;
    logic                idx_next_lt;
    logic                sidx_next_lt;
    logic [CW:0]         idx_inc;
    logic [CW:0]         sidx_inc;
    logic [CW:0]         sidx_inc2;

    ptts_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign idx_inc      = {1'b0, r_idx} + ONE;
    assign sidx_inc     = {1'b0, r_sidx} + ONE;
    assign sidx_inc2    = {1'b0, r_sidx} + TWO;
    assign table_full   = r_count == CW'(MAX_TASKS);
    assign walk_end     = (r_idx >= r_count) || (r_nres == NW'(RESULT_CAP));
    assign tick_last    = idx_inc == {1'b0, r_count};
    assign has_run      = ram_rdata.pending != '0;
    assign one_shot     = ram_rdata.period == '0;
    assign idx_next_lt  = idx_inc < {1'b0, r_count};
    assign sidx_next_lt = sidx_inc < {1'b0, r_count};

    // tick update of one entry
    always_comb begin
        tick_entry = ram_rdata;
        if (ram_rdata.delay != '0) begin
            tick_entry.delay = ram_rdata.delay - 1'b1;
        end else begin
            tick_entry.delay = ram_rdata.period;
            if (ram_rdata.pending != PEND_MAX) begin
                tick_entry.pending = ram_rdata.pending + 1'b1;
            end
        end
    end

    always_comb begin
        new_entry.handle  = i_q_head.handle;
        new_entry.delay   = i_q_head.delay_ticks;
        new_entry.period  = i_q_head.period_ticks;
        new_entry.pending = '0;
        ok_res            = '0;
        ok_res.accepted   = 1'b1;
        ok_res.last       = 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_head.kind)
                        KIND_TICK:     n_state = (r_count == '0) ? ST_IDLE : ST_TICK;
                        KIND_DISPATCH: n_state = ST_DSP_CHK;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TICK:     n_state = tick_last ? ST_IDLE : ST_TICK;
            ST_DSP_CHK:  n_state = walk_end ? ST_IDLE : ST_DSP_EVAL;
            ST_DSP_EVAL: begin
                if (has_run && one_shot && idx_next_lt) begin
                    n_state = ST_SHIFT;
                end else begin
                    n_state = ST_DSP_CHK;
                end
            end
            ST_SHIFT:    n_state = sidx_next_lt ? ST_SHIFT : ST_DSP_CHK;
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count       = r_count;
        n_idx         = r_idx;
        n_sidx        = r_sidx;
        n_nres        = r_nres;
        n_hold_valid  = r_hold_valid;
        n_hold_handle = r_hold_handle;
        n_out_valid   = 1'b0;
        n_out         = ok_res;
        ram_we        = 1'b0;
        ram_waddr     = r_idx[AW-1:0];
        ram_wdata     = ram_rdata;
        ram_raddr     = r_idx[AW-1:0];
        o_q_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    case (i_q_head.kind)
                        KIND_ADD: begin
                            n_out_valid = 1'b1;
                            if (!table_full) begin
                                ram_we     = 1'b1;
                                ram_waddr  = r_count[AW-1:0];
                                ram_wdata  = new_entry;
                                n_out.slot = SLOT_W'(r_count);
                                n_count    = r_count + 1'b1;
                            end else begin
                                n_out.accepted = 1'b0;
                            end
                        end
                        KIND_TICK: begin
                            n_idx       = '0;
                            ram_raddr   = '0;
                            n_out_valid = r_count == '0;
                        end
                        KIND_DISPATCH: begin
                            n_idx        = '0;
                            n_nres       = '0;
                            n_hold_valid = 1'b0;
                        end
                        default: begin
                            n_count     = '0;
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                ram_we      = 1'b1;
                ram_wdata   = tick_entry;
                ram_raddr   = idx_inc[AW-1:0];
                n_idx       = idx_inc[CW-1:0];
                n_out_valid = tick_last;
            end
            ST_DSP_CHK: begin
                if (walk_end) begin
                    n_out_valid  = 1'b1;
                    n_hold_valid = 1'b0;
                    if (r_hold_valid) begin
                        n_out.run_valid  = 1'b1;
                        n_out.run_handle = r_hold_handle;
                    end
                end
            end
            ST_DSP_EVAL: begin
                if (has_run) begin
                    n_nres        = r_nres + 1'b1;
                    n_hold_valid  = 1'b1;
                    n_hold_handle = ram_rdata.handle;
                    // earlier run goes out now that another follows it
                    if (r_hold_valid) begin
                        n_out_valid      = 1'b1;
                        n_out.run_valid  = 1'b1;
                        n_out.run_handle = r_hold_handle;
                        n_out.last       = 1'b0;
                    end
                    if (!one_shot) begin
                        ram_we            = 1'b1;
                        ram_wdata.pending = ram_rdata.pending - 1'b1;
                        n_idx             = idx_inc[CW-1:0];
                    end else begin
                        // one-shot leaves, index stays to re-check the moved entry
                        n_count   = r_count - 1'b1;
                        n_sidx    = r_idx;
                        ram_raddr = idx_inc[AW-1:0];
                    end
                end else begin
                    n_idx = idx_inc[CW-1:0];
                end
            end
            ST_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_sidx[AW-1:0];
                n_sidx    = sidx_inc[CW-1:0];
                ram_raddr = sidx_inc2[AW-1:0];
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_sidx       <= '0;
            r_nres       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_sidx       <= n_sidx;
            r_nres       <= n_nres;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
        r_hold_handle <= n_hold_handle;
        r_out         <= n_out;
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("task count beyond table size");

    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= NW'(RESULT_CAP))
        else $error("dispatch result count beyond cap");

    a_run_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.run_valid |->
            ($past(r_state) == ST_DSP_EVAL || $past(r_state) == ST_DSP_CHK))
        else $error("run result outside dispatch walk");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid && r_state == ST_IDLE)
        else $error("queue popped while empty or busy");

    a_hold_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DSP_CHK && walk_end |=> !r_hold_valid && r_out_valid && r_out.last)
        else $error("dispatch walk ended without final result");

endmodule

@@ hw/rtl/periodic_task_tick_scheduler.sv @@
// ============================================================================
// periodic_task_tick_scheduler
// time-triggered task table: add, tick, dispatch and clear requests
// ============================================================================
// usage
//   a request is taken at a clock edge with start high and busy low; it
//   carries kind (add, tick, dispatch, clear), a task handle and a delay and
//   period in ms, which the front turns into 10 ms ticks
//   results come on o_result, each valid for exactly one cycle while o_strobe
//   is high; the receiver cannot stall them, o_result.last marks the final
//   result of a request
//   add, tick and clear give one result; dispatch gives one result per task
//   run (up to 16) or one empty result
// request flow
//   front capture plus multiply, a two-entry queue, then the table sequencer
//   add and clear: handled in the sequencer's idle state, result registered
//   tick: one table entry per cycle, each read, updated and written back
//   dispatch: a check and an evaluate state per entry looked at, plus a shift
//   state per entry moved down when a one-shot task leaves; the table ram with
//   one write port and a registered read port sets this order of states
//   busy rises only when the queue and the front stage are both full
// reset
//   synchronous active-low reset empties the table and the queue; table
//   contents are not cleared, only the task count
// ============================================================================
module periodic_task_tick_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ptts_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_strobe,
    output ptts_pkg::t_result o_result
);
    import ptts_pkg::*;

    // front to queue
    logic  push;
    t_cmd  push_cmd;
    logic  q_full;

    // queue to back
    logic  q_valid;
    logic  q_pop;
    t_cmd  q_head;

    // capture and tick conversion
    ptts_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .o_busy   (busy),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // decouples capture from the table walk
    ptts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // table sequencer and result register
    ptts_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule
